/* design/ctc_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths and the 32-bit saturation for the computed-torque block
// no dependencies; imported by ctc_accel_law and computed_torque_control_law

package ctc_pkg;

  // field widths of the stream items
  localparam int ROW_W  = 6;
  localparam int DATA_W = 32;

  // width of the desired-acceleration sum before saturation
  localparam int SUM_W  = 66;

  // store write request from the acceleration datapath
  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] accel;
    logic [DATA_W-1:0] bias;
  } ctc_wr_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if ((v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1)) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

/* design/ctc_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies; used for the acceleration and bias stores

module ctc_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ctc_accel_law.sv */
`timescale 1ns / 1ps
// three-stage pipeline for the desired acceleration of one joint item
// depends on ctc_pkg; feeds store writes to the top level

module ctc_accel_law
  import ctc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     start_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic signed [DATA_W-1:0] position_i,
  input  logic signed [DATA_W-1:0] velocity_i,
  input  logic signed [DATA_W-1:0] position_ref_i,
  input  logic signed [DATA_W-1:0] velocity_ref_i,
  input  logic signed [DATA_W-1:0] accel_ref_i,
  input  logic signed [DATA_W-1:0] gain_p_i,
  input  logic signed [DATA_W-1:0] gain_d_i,
  input  logic signed [DATA_W-1:0] bias_torque_i,
  output ctc_wr_t                  wr_o,
  output logic                     busy_o
);

  localparam int ERR_W  = DATA_W + 1;
  localparam int PROD_W = DATA_W + ERR_W;

  logic v1_q, v2_q, v3_q;

  // stage 1: errors
  logic [ROW_W-1:0]         row1_q;
  logic signed [ERR_W-1:0]  perr1_q, verr1_q;
  logic signed [DATA_W-1:0] kp1_q, kd1_q, aref1_q, bias1_q;

  // stage 2: gain products
  logic [ROW_W-1:0]         row2_q;
  logic signed [PROD_W-1:0] pprod2_q, dprod2_q;
  logic signed [DATA_W-1:0] aref2_q, bias2_q;

  // stage 3: unsaturated acceleration
  logic [ROW_W-1:0]         row3_q;
  logic signed [SUM_W-1:0]  acc3_q;
  logic signed [DATA_W-1:0] bias3_q;

  logic signed [PROD_W-1:0] pterm, dterm;

  // floor shift of each product
  assign pterm = pprod2_q >>> FRAC_BITS;
  assign dterm = dprod2_q >>> FRAC_BITS;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      row1_q   <= row_i;
      perr1_q  <= ERR_W'(position_i) - ERR_W'(position_ref_i);
      verr1_q  <= ERR_W'(velocity_i) - ERR_W'(velocity_ref_i);
      kp1_q    <= gain_p_i;
      kd1_q    <= gain_d_i;
      aref1_q  <= accel_ref_i;
      bias1_q  <= bias_torque_i;

      row2_q   <= row1_q;
      pprod2_q <= PROD_W'(kp1_q) * PROD_W'(perr1_q);
      dprod2_q <= PROD_W'(kd1_q) * PROD_W'(verr1_q);
      aref2_q  <= aref1_q;
      bias2_q  <= bias1_q;

      row3_q   <= row2_q;
      acc3_q   <= SUM_W'(aref2_q) - SUM_W'(pterm) - SUM_W'(dterm);
      bias3_q  <= bias2_q;
    end
  end

  // saturated store write as the item leaves stage 3
  assign wr_o.en    = v3_q & adv_i;
  assign wr_o.row   = row3_q;
  assign wr_o.accel = sat32(acc3_q);
  assign wr_o.bias  = bias3_q;

  assign busy_o = v1_q | v2_q | v3_q;

endmodule

/* design/computed_torque_control_law.sv */
`timescale 1ns / 1ps
// computed-torque control law: joint items fill the acceleration and bias stores,
// matrix items multiply-accumulate row by row and emit a saturated torque per row.
// latency: a last-column matrix item passes stages m1, m2, e3, e4 and the output register.
// throughput: one item per cycle unless m_axis stalls; a matrix item after joint items
// waits until their store writes leave the 3-stage acceleration pipeline.
// reset: pipeline and accumulator cleared, joint_count set to 1, store contents undefined.

module computed_torque_control_law
  import ctc_pkg::*;
#(
  parameter int MAX_JOINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,

  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,

  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row, column, position, velocity, position_ref, velocity_ref, accel_ref,
  // gain_p, gain_d, bias_torque, mass_element, zero fill
  input  logic [303:0] s_axis_tdata,
  // action
  input  logic [0:0]   s_axis_tuser,

  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // joint, torque, zero fill
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int AW     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int NW     = $clog2(MAX_JOINTS + 1);
  localparam int CW     = (NW > 7) ? NW : 7;
  localparam int ACC_W  = 64;
  localparam int CLMP_W = 42;
  localparam int OUT_W  = 40;

  localparam int COL_LSB  = ROW_W;
  localparam int POS_LSB  = 2 * ROW_W;
  localparam int VEL_LSB  = POS_LSB + DATA_W;
  localparam int PREF_LSB = VEL_LSB + DATA_W;
  localparam int VREF_LSB = PREF_LSB + DATA_W;
  localparam int AREF_LSB = VREF_LSB + DATA_W;
  localparam int KP_LSB   = AREF_LSB + DATA_W;
  localparam int KD_LSB   = KP_LSB + DATA_W;
  localparam int BIAS_LSB = KD_LSB + DATA_W;
  localparam int MASS_LSB = BIAS_LSB + DATA_W;

  localparam logic ACT_MATRIX      = 1'b1;
  localparam logic REG_JOINT_COUNT = 1'b0;

  localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sd1 <<< 40;

  // input field views
  logic [ROW_W-1:0]         in_row, in_col;
  logic signed [DATA_W-1:0] in_mass;
  logic                     in_matrix;

  assign in_row    = s_axis_tdata[COL_LSB-1:0];
  assign in_col    = s_axis_tdata[POS_LSB-1:COL_LSB];
  assign in_mass   = s_axis_tdata[MASS_LSB+DATA_W-1:MASS_LSB];
  assign in_matrix = (s_axis_tuser[0] == ACT_MATRIX);

  // configuration register
  logic [6:0] joint_count_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_JOINT_COUNT) ? 32'(joint_count_q) : 32'd0;

  // active joint count, clamped to 1..MAX_JOINTS
  logic [CW-1:0] n_act;

  always_comb begin
    if (joint_count_q == 7'd0) begin
      n_act = CW'(1);
    end else if (CW'(joint_count_q) > CW'(MAX_JOINTS)) begin
      n_act = CW'(MAX_JOINTS);
    end else begin
      n_act = CW'(joint_count_q);
    end
  end

  // pipeline control
  logic adv, accept, joint_busy;
  logic m1_v_q, m2_v_q, e3_v_q, e4_v_q, m_valid_q;

  assign adv           = !(e4_v_q && m_valid_q && !m_axis_tready);
  assign s_axis_tready = adv && !(joint_busy && in_matrix);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // joint item pipeline
  ctc_wr_t wr;
  logic    joint_start;

  assign joint_start = accept && !in_matrix && (CW'(in_row) < CW'(MAX_JOINTS));

  ctc_accel_law #(
    .FRAC_BITS(FRAC_BITS)
  ) u_accel_law (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .start_i        (joint_start),
    .row_i          (in_row),
    .position_i     (s_axis_tdata[VEL_LSB-1:POS_LSB]),
    .velocity_i     (s_axis_tdata[PREF_LSB-1:VEL_LSB]),
    .position_ref_i (s_axis_tdata[VREF_LSB-1:PREF_LSB]),
    .velocity_ref_i (s_axis_tdata[AREF_LSB-1:VREF_LSB]),
    .accel_ref_i    (s_axis_tdata[KP_LSB-1:AREF_LSB]),
    .gain_p_i       (s_axis_tdata[KD_LSB-1:KP_LSB]),
    .gain_d_i       (s_axis_tdata[BIAS_LSB-1:KD_LSB]),
    .bias_torque_i  (s_axis_tdata[MASS_LSB-1:BIAS_LSB]),
    .wr_o           (wr),
    .busy_o         (joint_busy)
  );

  // acceleration and bias stores, read whenever an item is accepted
  logic [DATA_W-1:0] accel_rdata, bias_rdata;

  ctc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_JOINTS)
  ) u_accel_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (AW'(wr.row)),
    .wdata_i (wr.accel),
    .re_i    (accept),
    .raddr_i (AW'(in_col)),
    .rdata_o (accel_rdata)
  );

  ctc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_JOINTS)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (AW'(wr.row)),
    .wdata_i (wr.bias),
    .re_i    (accept),
    .raddr_i (AW'(in_row)),
    .rdata_o (bias_rdata)
  );

  // matrix item stage registers
  logic                     m1_ok;
  logic [ROW_W-1:0]         row1_q, row2_q, row3_q, row4_q, joint_q;
  logic signed [DATA_W-1:0] mass1_q, bias2_q, bias3_q, torque_q;
  logic                     first1_q, emit1_q, lrow1_q;
  logic                     first2_q, emit2_q, lrow2_q, last3_q, last4_q, last_q;
  logic signed [ACC_W-1:0]  mprod2_q, acc_q, em3_q;
  logic signed [CLMP_W-1:0] sum4_q;

  assign m1_ok = accept && in_matrix && (CW'(in_row) < n_act) && (CW'(in_col) < n_act);

  // row accumulation
  logic signed [ACC_W-1:0] prod_sh, row_sum, em_clamped;

  assign prod_sh = mprod2_q >>> FRAC_BITS;
  assign row_sum = (first2_q ? '0 : acc_q) + prod_sh;

  // clamp of the row sum before the bias is added
  always_comb begin
    if (em3_q > ACC_LIM) begin
      em_clamped = ACC_LIM;
    end else if (em3_q < -ACC_LIM) begin
      em_clamped = -ACC_LIM;
    end else begin
      em_clamped = em3_q;
    end
  end

  // control state, accumulator and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_count_q <= 7'd1;
      m1_v_q        <= 1'b0;
      m2_v_q        <= 1'b0;
      e3_v_q        <= 1'b0;
      e4_v_q        <= 1'b0;
      m_valid_q     <= 1'b0;
      acc_q         <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_JOINT_COUNT)) begin
        joint_count_q <= pwdata[6:0];
      end
      if (adv) begin
        m1_v_q <= m1_ok;
        m2_v_q <= m1_v_q;
        e3_v_q <= m2_v_q && emit2_q;
        e4_v_q <= e3_v_q;
        if (m2_v_q) begin
          acc_q <= emit2_q ? '0 : row_sum;
        end
      end
      if (adv && e4_v_q) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // matrix datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      row1_q   <= in_row;
      mass1_q  <= in_mass;
      first1_q <= (in_col == '0);
      emit1_q  <= (CW'(in_col) == n_act - CW'(1));
      lrow1_q  <= (CW'(in_row) == n_act - CW'(1));

      row2_q   <= row1_q;
      mprod2_q <= ACC_W'(mass1_q) * ACC_W'($signed(accel_rdata));
      bias2_q  <= $signed(bias_rdata);
      first2_q <= first1_q;
      emit2_q  <= emit1_q;
      lrow2_q  <= lrow1_q;

      row3_q   <= row2_q;
      em3_q    <= row_sum;
      bias3_q  <= bias2_q;
      last3_q  <= lrow2_q;

      row4_q   <= row3_q;
      sum4_q   <= CLMP_W'(em_clamped) + CLMP_W'(bias3_q);
      last4_q  <= last3_q;
    end
    if (adv && e4_v_q) begin
      joint_q  <= row4_q;
      torque_q <= sat32(SUM_W'(sum4_q));
      last_q   <= last4_q;
    end
  end

  // result item
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_W-ROW_W-DATA_W){1'b0}}, torque_q, joint_q};
  assign m_axis_tlast  = last_q;

endmodule

/* sim/tb_computed_torque_control_law.sv */
`timescale 1ns / 1ps
// testbench for computed_torque_control_law: joint and mass-matrix items in, torques out
// predicts every joint torque from its own copy of the stores and checks the result stream
// depends on ctc_pkg and the computed_torque_control_law rtl

module tb
  import ctc_pkg::*;
();

  localparam int FRAC      = 16;
  localparam int JOINTS    = 64;
  localparam int STALL_MAX = 2000;
  localparam int SETTLE    = 8;

  localparam logic ACT_JOINT = 1'b0;
  localparam logic ACT_MASS  = 1'b1;
  localparam logic [2:0] ADDR_JOINT_COUNT = 3'd0;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [2:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // row, column, position, velocity, position_ref, velocity_ref, accel_ref,
  // gain_p, gain_d, bias_torque, mass_element, zero fill
  logic [303:0] s_axis_tdata  = '0;
  // action
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // joint, torque, zero fill
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;

  computed_torque_control_law #(
    .MAX_JOINTS(JOINTS),
    .FRAC_BITS (FRAC)
  ) dut (.*);

  always #10 clk_i = ~clk_i;

  // expected torque of one row
  typedef struct packed {
    logic [ROW_W-1:0]  joint;
    logic [DATA_W-1:0] torque;
    logic              last;
  } torque_t;

  // predictor state
  logic signed [DATA_W-1:0] accel_tbl [JOINTS];
  logic signed [DATA_W-1:0] bias_tbl  [JOINTS];
  logic signed [63:0]       row_sum = '0;
  logic [6:0]               joint_count_reg = 7'd1;
  torque_t                  torque_q [$];

  int   errors         = 0;
  int   useful_items   = 0;
  int   quiet_cycles   = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_len       = 0;
  int   hold_left      = 0;
  logic hold_start     = 1'b0;

  function automatic int active_joints(input logic [6:0] v);
    if (v == 0) return 1;
    if (v > JOINTS) return JOINTS;
    return int'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return Q_MAX;
    if (v < -66'sd2147483648) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // control law on one accepted item, queues the torque a last column gives
  task automatic predict_item(input logic act, input logic [303:0] d);
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [DATA_W-1:0] pos, vel, pref, vref, aref, kp, kd, bias, mass;
    logic signed [32:0]       e_pos, e_vel;
    logic signed [65:0]       p_term, d_term;
    logic signed [63:0]       prod;
    logic signed [63:0]       lim;
    int                       n;
    torque_t                  t;
    row  = d[5:0];
    col  = d[11:6];
    pos  = d[43:12];
    vel  = d[75:44];
    pref = d[107:76];
    vref = d[139:108];
    aref = d[171:140];
    kp   = d[203:172];
    kd   = d[235:204];
    bias = d[267:236];
    mass = d[299:268];
    n    = active_joints(joint_count_reg);
    lim  = 64'sd1099511627776;
    if (act == ACT_JOINT) begin
      e_pos  = 33'(pos) - 33'(pref);
      e_vel  = 33'(vel) - 33'(vref);
      p_term = (66'(kp) * 66'(e_pos)) >>> FRAC;
      d_term = (66'(kd) * 66'(e_vel)) >>> FRAC;
      accel_tbl[row] = clamp32(66'(aref) - p_term - d_term);
      bias_tbl[row]  = bias;
      useful_items++;
    end else if (row < n && col < n) begin
      prod    = (64'(mass) * 64'(accel_tbl[col])) >>> FRAC;
      row_sum = (col == 0) ? prod : row_sum + prod;
      useful_items++;
      if (col == n - 1) begin
        prod = row_sum;
        if (prod > lim) prod = lim;
        if (prod < -lim) prod = -lim;
        t.joint  = row;
        t.torque = clamp32(66'(prod) + 66'(bias_tbl[row]));
        t.last   = (row == n - 1);
        torque_q.push_back(t);
        row_sum = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
  endtask

  task automatic check_torque();
    torque_t t;
    if (torque_q.size() == 0) begin
      report_mismatch("torque with nothing expected", 32'(m_axis_tdata[5:0]), '0);
    end else begin
      t = torque_q.pop_front();
      if (m_axis_tdata[5:0] !== t.joint) begin
        report_mismatch("joint", 32'(m_axis_tdata[5:0]), 32'(t.joint));
      end
      if (m_axis_tdata[37:6] !== t.torque) report_mismatch("torque", m_axis_tdata[37:6], t.torque);
      if (m_axis_tlast !== t.last) report_mismatch("last", 32'(m_axis_tlast), 32'(t.last));
    end
  endtask

  // monitor: check results, predict accepted items, watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_torque();
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser[0], s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_MAX) begin
        $display("FAIL computed_torque_control_law");
        $finish;
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left = hold_len;
      hold_start <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // signed Q16.16 value: extremes, small magnitudes or anything
  function automatic logic [DATA_W-1:0] rand_q();
    logic [DATA_W-1:0] pick;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       pick = Q_MAX;
          1:       pick = Q_MIN;
          2:       pick = '0;
          default: pick = '1;
        endcase
      end
      1, 2, 3: pick = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: pick = $urandom;
    endcase
    return pick;
  endfunction

  function automatic logic [303:0] pack_item(input logic [ROW_W-1:0] row, col,
                                             input logic [DATA_W-1:0] pos, vel, pref, vref,
                                             input logic [DATA_W-1:0] aref, kp, kd, bias, mass);
    return {4'b0, mass, bias, kd, kp, aref, vref, pref, vel, pos, col, row};
  endfunction

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(input logic act, input logic [303:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= bits;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_joint(input logic [ROW_W-1:0] row,
                            input logic [DATA_W-1:0] pos, vel, pref, vref,
                            input logic [DATA_W-1:0] aref, kp, kd, bias);
    send_item(ACT_JOINT, pack_item(row, 6'($urandom), pos, vel, pref, vref, aref, kp, kd,
                                   bias, $urandom));
  endtask

  task automatic send_random_joint(input logic [ROW_W-1:0] row);
    send_joint(row, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
               rand_q());
  endtask

  task automatic send_mass(input logic [ROW_W-1:0] row, col, input logic [DATA_W-1:0] mass);
    send_item(ACT_MASS, pack_item(row, col, $urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, mass));
  endtask

  // full matrix rows in row-major order
  task automatic send_rows(input int first, input int last_row, input int n);
    for (int r = first; r <= last_row; r++) begin
      for (int c = 0; c < n; c++) send_mass(6'(r), 6'(c), rand_q());
    end
  endtask

  // stop offering, wait for every torque, let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (torque_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write joint_count and read it back
  task automatic write_joint_count(input logic [6:0] val);
    logic [31:0] word;
    word      = $urandom;
    word[6:0] = val;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_JOINT_COUNT;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    joint_count_reg = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {25'b0, val}) report_mismatch("joint_count readback", prdata, {25'b0, val});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_joints(input logic [6:0] val);
    drain();
    write_joint_count(val);
  endtask

  // every store entry gets written before any matrix item reads it
  task automatic test_store_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int r = 0; r < JOINTS; r++) send_random_joint(6'(r));
  endtask

  task automatic test_special_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_joints(7'd2);
    // desired acceleration saturating low in both rows
    send_joint(0, Q_MAX, '0, Q_MIN, '0, '0, Q_MAX, '0, Q_MAX);
    send_joint(1, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    // row entered at its last column adds onto a cleared accumulator
    send_mass(0, 1, Q_MAX);
    // extreme elements over a full row, accumulator clamp
    send_mass(0, 0, Q_MIN);
    send_mass(0, 1, Q_MIN);
    // indexes beyond the joint count are ignored
    send_mass(2, 0, Q_MAX);
    send_mass(0, 5, Q_MAX);
    send_mass(63, 63, Q_MIN);
    // a second column 0 reloads the accumulator
    send_mass(1, 0, Q_ONE);
    send_mass(1, 0, 32'h0002_0000);
    send_mass(1, 1, 32'hFFFF_0000);
    // moderate values, nothing saturates
    send_joint(0, 32'h0001_8000, 32'h0000_4000, Q_ONE, '0, 32'h0000_2000, 32'h0004_0000,
               32'h0000_8000, 32'hFFFF_F000);
    send_mass(0, 0, Q_ONE);
    send_mass(0, 1, 32'h0000_8000);
    send_mass(1, 0, '0);
    send_mass(1, 1, '1);
    drain();
  endtask

  task automatic test_joint_count_limits();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // above the maximum: clipped to all joints
    set_joints(7'd127);
    send_rows(0, 0, JOINTS);
    send_rows(JOINTS - 1, JOINTS - 1, JOINTS);
    set_joints(7'd64);
    send_rows(31, 31, JOINTS);
    // zero acts as a single joint
    set_joints(7'd0);
    send_mass(0, 0, rand_q());
    send_mass(0, 1, rand_q());
    send_mass(1, 0, rand_q());
    send_mass(0, 0, Q_MIN);
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_joints(7'd1);
    hold_len = 300;
    hold_start <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i == 20) send_random_joint(0);
      send_mass(0, 0, rand_q());
    end
    drain();
  endtask

  // one control cycle, mostly well formed, sometimes broken
  task automatic random_step(input int n);
    int r;
    int c0;
    if ($urandom_range(99) < 85) begin
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(9) < 7) send_random_joint(6'(j));
      end
      send_rows(0, n - 1, n);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        r  = $urandom_range(n - 1);
        c0 = $urandom_range(n - 1);
        case ($urandom_range(3))
          0: send_random_joint(6'($urandom));
          1: send_mass(6'($urandom), 6'($urandom), rand_q());
          // row picked up mid-way
          2: for (int c = c0; c < n; c++) send_mass(6'(r), 6'(c), rand_q());
          // row abandoned part way, then restarted
          default: begin
            for (int c = 0; c <= c0 && c < n - 1; c++) send_mass(6'(r), 6'(c), rand_q());
            send_rows(r, r, n);
          end
        endcase
      end
    end
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int quota);
    int goal;
    int n;
    goal           = useful_items + quota;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (useful_items < goal) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      set_joints(7'(n));
      repeat ($urandom_range(1, 3)) random_step(n);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_store_fill();
    test_special_cases();
    test_joint_count_limits();
    test_backpressure();
    test_random_phase(0, 0, 60);
    test_random_phase(69, 0, 60);
    test_random_phase(0, 69, 60);
    test_random_phase(18, 18, 60);
    repeat (20) @(posedge clk_i);
    if (torque_q.size() != 0) report_mismatch("torques never seen", torque_q.size(), 0);
    if (errors == 0) begin
      $display("PASS computed_torque_control_law");
    end else begin
      $display("FAIL computed_torque_control_law");
    end
    $finish;
  end

endmodule
